/* rtl/hsnt_pkg.sv */
// Shared types and codes for the Hilbert-sorted node table.
`default_nettype none

package hsnt_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic        [63:0] key;
    logic        [31:0] child_page;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic        [6:0]  slot_index;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic        [6:0]  position;
    logic        [7:0]  entry_count;
    logic               node_empty;
    logic signed [31:0] union_min_x;
    logic signed [31:0] union_min_y;
    logic signed [31:0] union_max_x;
    logic signed [31:0] union_max_y;
    logic        [63:0] largest_key;
  } out_word_t;

  // control from the sequencer to the box accumulator
  typedef struct packed {
    logic take;
    logic first;
  } acc_ctrl_t;

endpackage

`default_nettype wire

/* rtl/hsnt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hsnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/hsnt_union.sv */
// Bounding-box accumulator: one min/max compare set reused for every entry.
`default_nettype none

module hsnt_union #(
  parameter int CW = 32
) (
  input  wire logic                  clk_i,
  input  wire hsnt_pkg::acc_ctrl_t   ctrl_i,
  input  wire logic signed [CW-1:0]  min_x_i,
  input  wire logic signed [CW-1:0]  min_y_i,
  input  wire logic signed [CW-1:0]  max_x_i,
  input  wire logic signed [CW-1:0]  max_y_i,
  output logic signed      [CW-1:0]  umin_x_o,
  output logic signed      [CW-1:0]  umin_y_o,
  output logic signed      [CW-1:0]  umax_x_o,
  output logic signed      [CW-1:0]  umax_y_o
);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      if (ctrl_i.first) begin
        umin_x_o <= min_x_i;
        umin_y_o <= min_y_i;
        umax_x_o <= max_x_i;
        umax_y_o <= max_y_i;
      end else begin
        if (min_x_i < umin_x_o) umin_x_o <= min_x_i;
        if (min_y_i < umin_y_o) umin_y_o <= min_y_i;
        if (max_x_i > umax_x_o) umax_x_o <= max_x_i;
        if (max_y_i > umax_y_o) umax_y_o <= max_y_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/hilbert_sorted_node_table_unit.sv */
// Top level: sorted node table sequencer, entry RAM and box accumulator.
//
//   channel | direction | handshake              | word
//   in      | into      | in_valid_i/in_stall_o  | hsnt_pkg::in_word_t
//   out     | out of    | out_valid_o/out_stall_i| hsnt_pkg::out_word_t
//
// One word at a time. An insert walks down from the top entry moving each
// larger key up one slot (one RAM move per cycle), a remove walks up from the
// index moving entries down; then a union pass reads every entry once through
// the single RAM read port.
// Reset clears only the count and control; the RAM holds no reset value.
// A finished word waits in the output register; a new word is taken meanwhile,
// but the next result waits while that word is still stalled.
`default_nettype none

module hilbert_sorted_node_table_unit #(
  parameter int CAPACITY   = 128,
  parameter int COORD_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire hsnt_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output hsnt_pkg::out_word_t       out_word_o
);

  localparam int CW      = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int AW      = $clog2(CAPACITY);
  localparam int CNTW    = $clog2(CAPACITY + 1);
  localparam int Y1_LO   = 0;
  localparam int X1_LO   = CW;
  localparam int Y0_LO   = 2 * CW;
  localparam int X0_LO   = 3 * CW;
  localparam int PG_LO   = 4 * CW;
  localparam int KEY_LO  = 4 * CW + 32;
  localparam int ENTRY_W = KEY_LO + 64;
  localparam logic [CNTW-1:0] CAP_C = CNTW'(CAPACITY);
  localparam logic [CNTW-1:0] ONE_C = CNTW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PLACE,
    S_REM,
    S_UN,
    S_WRAP
  } state_e;

  state_e              state_q, state_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [CNTW-1:0]     rd_idx_q, rd_idx_d;
  logic                take_q, take_d;
  logic                last_q, last_d;
  logic                first_q, first_d;
  logic [ENTRY_W-1:0]  new_q, new_d;
  hsnt_pkg::status_e   status_q, status_d;
  logic [6:0]          pos_q, pos_d;
  logic [63:0]         lkey_q, lkey_d;
  hsnt_pkg::out_word_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  hsnt_pkg::acc_ctrl_t acc_ctrl;
  logic signed [CW-1:0] umin_x, umin_y, umax_x, umax_y;

  logic [CNTW-1:0]     cnt_m1;
  logic [CNTW+6:0]     slot_ext, cnt_ext, slot_p1;
  logic [AW+6:0]       ptr_wide;
  logic [CNTW+7:0]     cnt_wide;
  logic [CW+31:0]      ext_min_x, ext_min_y, ext_max_x, ext_max_y;
  logic [63:0]         rd_key, new_key;

  assign cnt_m1   = cnt_q - ONE_C;
  assign slot_ext = {{CNTW{1'b0}}, in_word_i.slot_index};
  assign cnt_ext  = {7'b0, cnt_q};
  assign slot_p1  = slot_ext + (CNTW + 7)'(1);
  assign ptr_wide = {7'b0, ptr_q};
  assign cnt_wide = {8'b0, cnt_q};
  assign rd_key   = ram_rdata[KEY_LO +: 64];
  assign new_key  = new_q[KEY_LO +: 64];

  assign ext_min_x = {{32{umin_x[CW-1]}}, umin_x};
  assign ext_min_y = {{32{umin_y[CW-1]}}, umin_y};
  assign ext_max_x = {{32{umax_x[CW-1]}}, umax_x};
  assign ext_max_y = {{32{umax_y[CW-1]}}, umax_y};

  assign acc_ctrl.take  = take_q;
  assign acc_ctrl.first = first_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    rd_idx_d    = rd_idx_q;
    take_d      = 1'b0;
    last_d      = last_q;
    first_d     = first_q;
    new_d       = new_q;
    status_d    = status_q;
    pos_d       = pos_q;
    lkey_d      = lkey_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = new_q;
    ram_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          new_d = {in_word_i.key, in_word_i.child_page,
                   in_word_i.box_min_x[CW-1:0], in_word_i.box_min_y[CW-1:0],
                   in_word_i.box_max_x[CW-1:0], in_word_i.box_max_y[CW-1:0]};
          status_d = hsnt_pkg::ST_OK;
          rd_idx_d = '0;
          if (in_word_i.op == hsnt_pkg::OP_INSERT) begin
            pos_d = '0;
            if (cnt_q == CAP_C) begin
              status_d = hsnt_pkg::ST_FULL;
              state_d  = S_UN;
            end else if (cnt_q == '0) begin
              ptr_d   = '0;
              state_d = S_PLACE;
            end else begin
              ram_raddr = cnt_m1[AW-1:0];
              ptr_d     = cnt_m1[AW-1:0];
              state_d   = S_INS;
            end
          end else begin
            pos_d = in_word_i.slot_index;
            if (slot_ext >= cnt_ext) begin
              status_d = hsnt_pkg::ST_RANGE;
              state_d  = S_UN;
            end else if (slot_p1 == cnt_ext) begin
              // last entry: nothing to move
              cnt_d   = cnt_m1;
              state_d = S_UN;
            end else begin
              ram_raddr = slot_p1[AW-1:0];
              ptr_d     = slot_p1[AW-1:0];
              state_d   = S_REM;
            end
          end
        end
      end
      S_INS: begin
        // read data holds the entry at ptr; the next one below is fetched now
        ram_raddr = ptr_q - AW'(1);
        if (rd_key > new_key) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q + AW'(1);
          ram_wdata = ram_rdata;
          if (ptr_q == '0) begin
            state_d = S_PLACE;
          end else begin
            ptr_d = ptr_q - AW'(1);
          end
        end else begin
          ptr_d   = ptr_q + AW'(1);
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = new_q;
        pos_d     = ptr_wide[6:0];
        cnt_d     = cnt_q + ONE_C;
        state_d   = S_UN;
      end
      S_REM: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q - AW'(1);
        ram_wdata = ram_rdata;
        ram_raddr = ptr_q + AW'(1);
        if (CNTW'(ptr_q) == cnt_m1) begin
          cnt_d   = cnt_m1;
          state_d = S_UN;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_UN: begin
        if (rd_idx_q < cnt_q) begin
          ram_raddr = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + ONE_C;
          take_d    = 1'b1;
          last_d    = (rd_idx_q == cnt_m1);
          first_d   = (rd_idx_q == '0);
        end
        if (cnt_q == '0) begin
          state_d = S_WRAP;
        end else if (take_q && last_q) begin
          lkey_d  = rd_key;
          take_d  = 1'b0;
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status      = status_q;
          out_d.position    = pos_q;
          out_d.entry_count = cnt_wide[7:0];
          if (cnt_q == '0) begin
            out_d.node_empty  = 1'b1;
            out_d.union_min_x = '0;
            out_d.union_min_y = '0;
            out_d.union_max_x = '0;
            out_d.union_max_y = '0;
            out_d.largest_key = '0;
          end else begin
            out_d.node_empty  = 1'b0;
            out_d.union_min_x = ext_min_x[31:0];
            out_d.union_min_y = ext_min_y[31:0];
            out_d.union_max_x = ext_max_x[31:0];
            out_d.union_max_y = ext_max_y[31:0];
            out_d.largest_key = lkey_q;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      take_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      take_q      <= take_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      rd_idx_q    <= rd_idx_d;
      last_q      <= last_d;
      first_q     <= first_d;
      new_q       <= new_d;
      status_q    <= status_d;
      pos_q       <= pos_d;
      lkey_q      <= lkey_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  hsnt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  hsnt_union #(
    .CW(CW)
  ) u_union (
    .clk_i   (clk_i),
    .ctrl_i  (acc_ctrl),
    .min_x_i ($signed(ram_rdata[X0_LO +: CW])),
    .min_y_i ($signed(ram_rdata[Y0_LO +: CW])),
    .max_x_i ($signed(ram_rdata[X1_LO +: CW])),
    .max_y_i ($signed(ram_rdata[Y1_LO +: CW])),
    .umin_x_o(umin_x),
    .umin_y_o(umin_y),
    .umax_x_o(umax_x),
    .umax_y_o(umax_y)
  );

  // page field is carried through the RAM only
  logic [31:0] unused_page;
  assign unused_page = ram_rdata[PG_LO +: 32];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_C)
    else $error("entry count above capacity");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRAP && status_q == hsnt_pkg::ST_FULL) |-> (cnt_q == CAP_C))
    else $error("full status on a node with room");

  a_rem_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REM) |-> (CNTW'(ptr_q) < cnt_q))
    else $error("remove walk past last entry");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_valid_i) |=> (state_q == S_IDLE))
    else $error("sequencer left idle without a word");

endmodule

`default_nettype wire

/* tb/tb_hilbert_sorted_node_table_unit.sv */
// Self-checking testbench for the Hilbert-sorted node table: shadow node, random traffic.
`timescale 1ns / 100ps

module tb_hilbert_sorted_node_table_unit;

  localparam int NODE_SLOTS   = 128;
  localparam int TARGET_OPS   = 1420;
  localparam int DRAIN_CYCLES = 600;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  hsnt_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hsnt_pkg::out_word_t out_word_o;

  hilbert_sorted_node_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the node, kept in key order
  logic        [63:0] node_keys  [NODE_SLOTS];
  logic        [31:0] node_pages [NODE_SLOTS];
  logic signed [31:0] node_min_x [NODE_SLOTS];
  logic signed [31:0] node_min_y [NODE_SLOTS];
  logic signed [31:0] node_max_x [NODE_SLOTS];
  logic signed [31:0] node_max_y [NODE_SLOTS];
  int                 node_fill = 0;

  hsnt_pkg::in_word_t  pending_ops[$];
  hsnt_pkg::out_word_t due_summaries[$];
  hsnt_pkg::out_word_t got_due;
  int                  planned_fill = 0;
  int                  words_taken  = 0;
  int                  fail_count   = 0;
  int                  cycle_count  = 0;

  task automatic apply_node_op(input hsnt_pkg::in_word_t w, output hsnt_pkg::out_word_t r);
    int i;
    int pos;
    hsnt_pkg::status_e st;
    logic signed [31:0] ux0, uy0, ux1, uy1;
    st  = hsnt_pkg::ST_OK;
    pos = 0;
    r   = '0;
    if (w.op == hsnt_pkg::OP_INSERT) begin
      if (node_fill >= NODE_SLOTS) begin
        st = hsnt_pkg::ST_FULL;
      end else begin
        // strictly greater keys form a suffix; move it up, equal keys stay below
        i = node_fill - 1;
        while (i >= 0 && node_keys[i] > w.key) begin
          node_keys[i+1]  = node_keys[i];
          node_pages[i+1] = node_pages[i];
          node_min_x[i+1] = node_min_x[i];
          node_min_y[i+1] = node_min_y[i];
          node_max_x[i+1] = node_max_x[i];
          node_max_y[i+1] = node_max_y[i];
          i--;
        end
        pos = i + 1;
        node_keys[pos]  = w.key;
        node_pages[pos] = w.child_page;
        node_min_x[pos] = w.box_min_x;
        node_min_y[pos] = w.box_min_y;
        node_max_x[pos] = w.box_max_x;
        node_max_y[pos] = w.box_max_y;
        node_fill++;
      end
    end else begin
      pos = w.slot_index;
      if (pos >= node_fill) begin
        st = hsnt_pkg::ST_RANGE;
      end else begin
        for (i = pos; i + 1 < node_fill; i++) begin
          node_keys[i]  = node_keys[i+1];
          node_pages[i] = node_pages[i+1];
          node_min_x[i] = node_min_x[i+1];
          node_min_y[i] = node_min_y[i+1];
          node_max_x[i] = node_max_x[i+1];
          node_max_y[i] = node_max_y[i+1];
        end
        node_fill--;
      end
    end
    r.status      = st;
    r.position    = pos[6:0];
    r.entry_count = node_fill[7:0];
    if (node_fill == 0) begin
      r.node_empty = 1'b1;
    end else begin
      ux0 = node_min_x[0];
      uy0 = node_min_y[0];
      ux1 = node_max_x[0];
      uy1 = node_max_y[0];
      for (i = 1; i < node_fill; i++) begin
        if (node_min_x[i] < ux0) ux0 = node_min_x[i];
        if (node_min_y[i] < uy0) uy0 = node_min_y[i];
        if (node_max_x[i] > ux1) ux1 = node_max_x[i];
        if (node_max_y[i] > uy1) uy1 = node_max_y[i];
      end
      r.union_min_x = ux0;
      r.union_min_y = uy0;
      r.union_max_x = ux1;
      r.union_max_y = uy1;
      r.largest_key = node_keys[node_fill-1];
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // idling phases follow the words taken: none, sender, receiver, both
  function automatic bit sender_idles();
    int ph;
    ph = (words_taken / 100) % 4;
    if (ph == 1) return $urandom_range(99) < 67;
    if (ph == 3) return $urandom_range(99) < 19;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    int ph;
    ph = (words_taken / 100) % 4;
    if (ph == 2) return $urandom_range(99) < 67;
    if (ph == 3) return $urandom_range(99) < 19;
    return 1'b0;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic hsnt_pkg::in_word_t make_op(input hsnt_pkg::op_e op,
                                                 input logic [6:0] idx);
    hsnt_pkg::in_word_t w;
    w.op         = op;
    w.slot_index = idx;
    w.child_page = $urandom;
    // small and extreme keys give plenty of equal keys
    case ($urandom_range(3))
      0:       w.key = 64'($urandom_range(15));
      1:       w.key = $urandom_range(1) ? '1 : '0;
      default: w.key = {$urandom, $urandom};
    endcase
    case ($urandom_range(3))
      0: begin
        w.box_min_x = $urandom;
        w.box_min_y = $urandom;
        w.box_max_x = $urandom;
        w.box_max_y = $urandom;
      end
      1: begin
        w.box_min_x = pick_extreme();
        w.box_min_y = pick_extreme();
        w.box_max_x = pick_extreme();
        w.box_max_y = pick_extreme();
      end
      default: begin
        w.box_min_x = $urandom;
        w.box_min_y = $urandom;
        w.box_max_x = w.box_min_x + $urandom_range(4095);
        w.box_max_y = w.box_min_y + $urandom_range(4095);
      end
    endcase
    return w;
  endfunction

  task automatic queue_op(input hsnt_pkg::in_word_t w);
    pending_ops.push_back(w);
    if (w.op == hsnt_pkg::OP_INSERT) begin
      if (planned_fill < NODE_SLOTS) planned_fill++;
    end else if (w.slot_index < planned_fill) begin
      planned_fill--;
    end
  endtask

  task automatic queue_remove(input int idx);
    queue_op(make_op(hsnt_pkg::OP_REMOVE, idx[6:0]));
  endtask

  task automatic queue_insert(input logic [63:0] k, input logic [31:0] pg);
    hsnt_pkg::in_word_t w;
    w            = make_op(hsnt_pkg::OP_INSERT, 7'($urandom_range(127)));
    w.key        = k;
    w.child_page = pg;
    queue_op(w);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_node_op(in_word_i, got_due);
        due_summaries.push_back(got_due);
        words_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() > 0 && !sender_idles()) begin
          in_word_i  <= pending_ops.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  hsnt_pkg::out_word_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_summaries.size() == 0) begin
          $error("result word with nothing outstanding");
          fail_count++;
        end else begin
          want = due_summaries.pop_front();
          check_field("status",      want.status,      out_word_o.status);
          check_field("position",    want.position,    out_word_o.position);
          check_field("entry_count", want.entry_count, out_word_o.entry_count);
          check_field("node_empty",  want.node_empty,  out_word_o.node_empty);
          check_field("union_min_x", want.union_min_x, out_word_o.union_min_x);
          check_field("union_min_y", want.union_min_y, out_word_o.union_min_y);
          check_field("union_max_x", want.union_max_x, out_word_o.union_max_x);
          check_field("union_max_y", want.union_max_y, out_word_o.union_max_y);
          check_field("largest_key", want.largest_key, out_word_o.largest_key);
        end
      end
      out_stall_i <= receiver_stalls();
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    hsnt_pkg::in_word_t w;
    int                 mode;
    bit                 first_seq;

    // directed: empty node, extreme keys and boxes, equal keys, edge indices
    queue_remove(0);
    queue_remove(127);
    w            = make_op(hsnt_pkg::OP_INSERT, '0);
    w.key        = '0;
    w.child_page = '0;
    w.box_min_x  = 32'sh8000_0000;
    w.box_min_y  = 32'sh8000_0000;
    w.box_max_x  = 32'sh7fff_ffff;
    w.box_max_y  = 32'sh7fff_ffff;
    queue_op(w);
    w            = make_op(hsnt_pkg::OP_INSERT, '1);
    w.key        = '1;
    w.child_page = '1;
    w.box_min_x  = 32'sh7fff_ffff;          // inverted box
    w.box_min_y  = 32'sh7fff_ffff;
    w.box_max_x  = 32'sh8000_0000;
    w.box_max_y  = 32'sh8000_0000;
    queue_op(w);
    queue_insert(64'd5, 32'd1);
    queue_insert(64'd5, 32'd2);
    queue_insert(64'd5, 32'd3);
    queue_insert(64'd3, 32'd4);
    queue_insert(64'h8000_0000_0000_0000, 32'd5);
    queue_remove(3);
    queue_remove(planned_fill - 1);
    queue_remove(planned_fill);
    queue_remove(0);
    queue_insert('1, 32'd6);
    while (planned_fill > 0) queue_remove(0);
    queue_insert(64'd9, 32'd7);

    // random: fills up to full, drains to empty, and mixed traffic
    first_seq = 1'b1;
    while (pending_ops.size() < TARGET_OPS) begin
      mode = first_seq ? 0 : $urandom_range(4);
      first_seq = 1'b0;
      case (mode)
        0, 1: begin
          while (planned_fill < NODE_SLOTS)
            queue_op(make_op(hsnt_pkg::OP_INSERT, 7'($urandom_range(127))));
          repeat ($urandom_range(3, 1))
            queue_op(make_op(hsnt_pkg::OP_INSERT, 7'($urandom_range(127))));
        end
        2: begin
          while (planned_fill > 0) queue_remove($urandom_range(planned_fill - 1));
          queue_remove($urandom_range(127, 0));
        end
        default: begin
          repeat ($urandom_range(80, 20)) begin
            mode = $urandom_range(99);
            if (mode < 55)
              queue_op(make_op(hsnt_pkg::OP_INSERT, 7'($urandom_range(127))));
            else if (mode < 90 && planned_fill > 0)
              queue_remove($urandom_range(planned_fill - 1));
            else
              queue_remove($urandom_range(127));
          end
        end
      endcase
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid_i || due_summaries.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
